// ===== hdl/ssvh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssvh_pkg
// Types, constants and functions shared by the salted hash block and its testbench.
// ----------------------------------------------------------------------------
package ssvh_pkg;

    localparam int WordW      = 32;
    localparam int SchedDepth = 64;

    localparam logic [31:0] SALT_W14   = 32'h45534841;
    localparam logic [31:0] SALT_W15   = 32'h2D323536 ^ 32'h00000001;
    localparam logic [31:0] FINAL_MARK = 32'h80000000;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // Words that are salted on their way out of the schedule RAM.
    function automatic logic [31:0] sched_mask(input logic [5:0] addr,
                                               input logic [63:0] bits_before,
                                               input logic fin);
        case (addr)
            6'd0:    sched_mask = bits_before[63:32];
            6'd1:    sched_mask = bits_before[31:0];
            6'd2:    sched_mask = fin ? FINAL_MARK : 32'h0;
            6'd13:   sched_mask = fin ? FINAL_MARK : 32'h0;
            6'd14:   sched_mask = SALT_W14;
            6'd15:   sched_mask = SALT_W15;
            default: sched_mask = 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        case (i)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

// ===== hdl/salted_sha256_variant_hash.sv =====
// ----------------------------------------------------------------------------
// salted_sha256_variant_hash
// Streaming salted SHA-256 variant: bytes in, eight digest words out.
// ----------------------------------------------------------------------------
// Usage: the msg channel takes one item per handshake. An item carries an
// optional message byte (byte_valid) and an end-of-message flag. The block
// takes byte items back to back while it is only buffering. When a byte
// completes a 64-byte block, the block stalls msg_ready while it compresses.
// A compression runs schedule expansion in 12 groups (four reads of the
// source group, then four lane writes into the schedule RAM), a round setup
// step, 64 rounds and an add into the chaining value. The schedule RAM also
// holds the block. At end of message the padding words are written one per
// cycle and one or two blocks are compressed; then the digest channel offers
// the eight words in order, word_index 0 first, last_word on word 7. If the
// receiver stalls, the current word is held until taken, and no new message
// item is accepted until all eight are delivered. Reset restores the initial
// hash words and clears fill and bit counters; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module salted_sha256_variant_hash (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssvh_pkg::msg_item_t   msg,
    input  logic                  msg_valid,
    output logic                  msg_ready,
    output ssvh_pkg::digest_item_t digest,
    output logic                  digest_valid,
    input  logic                  digest_ready
);

    import ssvh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_EXP, S_RPRE, S_RND, S_ADD, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [23:0] acc_reg, acc_next;
    logic [63:0] count_reg, count_next;
    logic [63:0] bbb_reg, bbb_next;
    logic        final_reg, final_next;
    logic        padding_reg, padding_next;
    logic        end_pend_reg, end_pend_next;
    logic        pad_pend_reg, pad_pend_next;
    logic [31:0] padword_reg, padword_next;
    logic [3:0]  wp_reg, wp_next;
    logic [3:0]  grp_reg, grp_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [5:0]  ri_reg, ri_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic [5:0]  rq_reg;
    logic [31:0] cv_reg [8];
    logic [31:0] cv_next [8];
    logic [31:0] r_reg [8];
    logic [31:0] r_next [8];
    logic [31:0] win_reg [4];
    logic [31:0] win_next [4];

    logic        ram_we;
    logic [5:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata, wmask;

    logic [31:0] acc_word;
    logic [5:0]  pad_fill;
    logic [1:0]  jj;
    logic [31:0] t1, t2;

    ssvh_ram #(.WIDTH(WordW), .DEPTH(SchedDepth)) u_sched (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Salt, bit count and final marker are folded in as words leave the RAM.
    assign wmask = ram_rdata ^ sched_mask(rq_reg, bbb_reg, final_reg);

    assign msg_ready    = (state_reg == S_IDLE);
    assign digest_valid = (state_reg == S_OUT);
    assign digest.digest_word = cv_reg[oidx_reg];
    assign digest.word_index  = oidx_reg;
    assign digest.last_word   = (oidx_reg == 3'd7);

    assign jj = cnt_reg[1:0] - 2'd1;

    always_comb
    begin
        t1 = r_reg[7] + big_s1(r_reg[4]) +
             ((r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6])) +
             round_k(ri_reg) + wmask;
        t2 = big_s0(r_reg[0]) +
             ((r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]));
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        acc_next      = acc_reg;
        count_next    = count_reg;
        bbb_next      = bbb_reg;
        final_next    = final_reg;
        padding_next  = padding_reg;
        end_pend_next = end_pend_reg;
        pad_pend_next = pad_pend_reg;
        padword_next  = padword_reg;
        wp_next       = wp_reg;
        grp_next      = grp_reg;
        cnt_next      = cnt_reg;
        ri_next       = ri_reg;
        oidx_next     = oidx_reg;
        cv_next       = cv_reg;
        r_next        = r_reg;
        win_next      = win_reg;
        ram_we        = 1'b0;
        ram_waddr     = 6'd0;
        ram_wdata     = 32'h0;
        ram_raddr     = 6'd0;
        acc_word      = {acc_reg, msg.data_byte};
        pad_fill      = fill_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.byte_valid)
                    begin
                        acc_next   = acc_word[23:0];
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 64'd8;
                        pad_fill   = fill_reg + 6'd1;
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = {2'b00, fill_reg[5:2]};
                            ram_wdata = acc_word;
                        end
                    end
                    if (msg.byte_valid && (fill_reg == 6'd63))
                    begin
                        end_pend_next = msg.end_of_message;
                        final_next    = 1'b0;
                        padding_next  = 1'b0;
                        grp_next      = 4'd4;
                        cnt_next      = 4'd0;
                        state_next    = S_EXP;
                    end
                    else if (msg.end_of_message)
                    begin
                        // The partial word's bytes sit in the low end of the
                        // accumulator; the pad byte follows them.
                        case (pad_fill[1:0])
                            2'd0:    padword_next = {PAD_BYTE, 24'h0};
                            2'd1:    padword_next = {acc_next[7:0], PAD_BYTE, 16'h0};
                            2'd2:    padword_next = {acc_next[15:0], PAD_BYTE, 8'h0};
                            default: padword_next = {acc_next[23:0], PAD_BYTE};
                        endcase
                        wp_next       = pad_fill[5:2];
                        pad_pend_next = 1'b1;
                        final_next    = (pad_fill[5:3] != 3'd7);
                        padding_next  = 1'b1;
                        state_next    = S_FILL;
                    end
                end
            end

            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = {2'b00, wp_reg};
                if (pad_pend_reg)
                begin
                    ram_wdata = padword_reg;
                end
                else if (final_reg && (wp_reg == 4'd14))
                begin
                    ram_wdata = count_reg[63:32];
                end
                else if (final_reg && (wp_reg == 4'd15))
                begin
                    ram_wdata = count_reg[31:0];
                end
                else
                begin
                    ram_wdata = 32'h0;
                end
                pad_pend_next = 1'b0;
                wp_next       = wp_reg + 4'd1;
                if (wp_reg == 4'd15)
                begin
                    grp_next   = 4'd4;
                    cnt_next   = 4'd0;
                    state_next = S_EXP;
                end
            end

            S_EXP:
            begin
                // Reads of the source group, then four lane writes.
                if (cnt_reg < 4'd4)
                begin
                    ram_raddr = {grp_reg - 4'd4, cnt_reg[1:0]};
                end
                if ((cnt_reg >= 4'd1) && (cnt_reg <= 4'd4))
                begin
                    win_next[jj] = wmask;
                end
                if (cnt_reg >= 4'd5)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {grp_reg, jj};
                    ram_wdata = small_s1(win_reg[jj]) + win_reg[jj + 2'd3] +
                                small_s0(win_reg[jj + 2'd1]) + win_reg[jj + 2'd2];
                end
                if (cnt_reg == 4'd8)
                begin
                    cnt_next = 4'd0;
                    if (grp_reg == 4'd15)
                    begin
                        state_next = S_RPRE;
                    end
                    else
                    begin
                        grp_next = grp_reg + 4'd1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end

            S_RPRE:
            begin
                ram_raddr  = 6'd0;
                r_next     = cv_reg;
                ri_next    = 6'd0;
                state_next = S_RND;
            end

            S_RND:
            begin
                ram_raddr = ri_reg + 6'd1;
                r_next[7] = r_reg[6];
                r_next[6] = r_reg[5];
                r_next[5] = r_reg[4];
                r_next[4] = r_reg[3] + t1;
                r_next[3] = r_reg[2];
                r_next[2] = r_reg[1];
                r_next[1] = r_reg[0];
                r_next[0] = t1 + t2;
                ri_next   = ri_reg + 6'd1;
                if (ri_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    cv_next[i] = cv_reg[i] + r_reg[i];
                end
                bbb_next = bbb_reg + 64'd512;
                if (final_reg)
                begin
                    oidx_next  = 3'd0;
                    state_next = S_OUT;
                end
                else if (padding_reg)
                begin
                    wp_next       = 4'd0;
                    final_next    = 1'b1;
                    pad_pend_next = 1'b0;
                    state_next    = S_FILL;
                end
                else if (end_pend_reg)
                begin
                    wp_next       = 4'd0;
                    final_next    = 1'b1;
                    pad_pend_next = 1'b1;
                    padword_next  = {PAD_BYTE, 24'h0};
                    padding_next  = 1'b1;
                    end_pend_next = 1'b0;
                    state_next    = S_FILL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_OUT:
            begin
                if (digest_ready)
                begin
                    if (oidx_reg == 3'd7)
                    begin
                        cv_next      = INIT_HASH;
                        fill_next    = 6'd0;
                        count_next   = 64'd0;
                        bbb_next     = 64'd0;
                        padding_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= 6'd0;
            count_reg    <= 64'd0;
            bbb_reg      <= 64'd0;
            final_reg    <= 1'b0;
            padding_reg  <= 1'b0;
            end_pend_reg <= 1'b0;
            pad_pend_reg <= 1'b0;
            wp_reg       <= 4'd0;
            grp_reg      <= 4'd0;
            cnt_reg      <= 4'd0;
            ri_reg       <= 6'd0;
            oidx_reg     <= 3'd0;
            cv_reg       <= INIT_HASH;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            bbb_reg      <= bbb_next;
            final_reg    <= final_next;
            padding_reg  <= padding_next;
            end_pend_reg <= end_pend_next;
            pad_pend_reg <= pad_pend_next;
            wp_reg       <= wp_next;
            grp_reg      <= grp_next;
            cnt_reg      <= cnt_next;
            ri_reg       <= ri_next;
            oidx_reg     <= oidx_next;
            cv_reg       <= cv_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        padword_reg <= padword_next;
        r_reg       <= r_next;
        win_reg     <= win_next;
        rq_reg      <= ram_raddr;
    end

endmodule

// ===== hdl/ssvh_ram.sv =====
// ----------------------------------------------------------------------------
// ssvh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ssvh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/salted_sha256_variant_hash_test.sv =====
// ----------------------------------------------------------------------------
// salted_sha256_variant_hash_test
// Self-checking bench for the streaming salted hash block.
// ----------------------------------------------------------------------------
// Message items are queued by a stimulus process and driven in random bursts
// on the falling edge. Each accepted item updates a predictor that mirrors the
// salted compression, and every end of message queues eight expected digest
// words. A monitor takes digest items at the rising edge under a stall pattern
// and compares them field by field against the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module salted_sha256_variant_hash_test;
    import ssvh_pkg::*;

    localparam int IdleLimit  = 20000;
    localparam int HoldCycles = 1500;

    // Round constants, kept locally so the predictor is independent of the RTL.
    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic         clk;
    logic         rst_n;
    msg_item_t    msg;
    logic         msg_valid;
    logic         msg_ready;
    digest_item_t digest;
    logic         digest_valid;
    logic         digest_ready;

    salted_sha256_variant_hash DUT (
        .clk(clk), .rst_n(rst_n),
        .msg(msg), .msg_valid(msg_valid), .msg_ready(msg_ready),
        .digest(digest), .digest_valid(digest_valid), .digest_ready(digest_ready)
    );

    // Predictor state: chaining words, the partial block and the bit counters.
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int          fill_count;
    logic [63:0] msg_bits;
    logic [63:0] hashed_bits;

    msg_item_t    pending_items [$];
    digest_item_t expected_words [$];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           hold_receiver = 0;
    bit           msg_taken = 0;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One salted compression of block_bytes into hash_state.
    task automatic compress(input bit last_block);
        logic [31:0] w [64];
        logic [31:0] r [8];
        logic [31:0] t1;
        logic [31:0] t2;
        int b;
        int j;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                    block_bytes[4*i+2], block_bytes[4*i+3]};
        w[0]  ^= hashed_bits[63:32];
        w[1]  ^= hashed_bits[31:0];
        w[14] ^= 32'h45534841;
        w[15] ^= 32'h2D323536 ^ 32'h00000001;
        if (last_block)
        begin
            w[2]  ^= 32'h80000000;
            w[13] ^= 32'h80000000;
        end
        // Four interleaved lanes: word 4t+j draws on all four words of group t-4, sigma1 on lane j.
        for (int i = 16; i < 64; i++)
        begin
            b = (i & ~3) - 16;
            j = i & 3;
            w[i] = (ror(w[b+j], 17) ^ ror(w[b+j], 19) ^ (w[b+j] >> 10))
                 + w[b + ((j + 3) & 3)]
                 + (ror(w[b + ((j+1)&3)], 7) ^ ror(w[b + ((j+1)&3)], 18)
                    ^ (w[b + ((j+1)&3)] >> 3))
                 + w[b + ((j + 2) & 3)];
        end
        for (int i = 0; i < 8; i++)
            r[i] = hash_state[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
               + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RK[i] + w[i];
            t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
               + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += r[i];
        hashed_bits += 64'd512;
    endtask

    task automatic hash_restart();
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV[i];
        fill_count  = 0;
        msg_bits    = '0;
        hashed_bits = '0;
    endtask

    // Apply one accepted message item to the predictor.
    task automatic absorb_item(input msg_item_t it);
        digest_item_t d;
        if (it.byte_valid)
        begin
            block_bytes[fill_count] = it.data_byte;
            fill_count++;
            msg_bits += 64'd8;
            if (fill_count == 64)
            begin
                compress(1'b0);
                fill_count = 0;
            end
        end
        if (it.end_of_message)
        begin
            block_bytes[fill_count] = 8'h80;
            for (int i = fill_count + 1; i < 64; i++)
                block_bytes[i] = 8'h00;
            // No room for the length: the padding spills into a second block.
            if (fill_count >= 56)
            begin
                compress(1'b0);
                for (int i = 0; i < 64; i++)
                    block_bytes[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[56 + i] = msg_bits[63 - 8*i -: 8];
            compress(1'b1);
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_state[i];
                d.word_index  = i[2:0];
                d.last_word   = (i == 7);
                expected_words.push_back(d);
            end
            hash_restart();
        end
    endtask

    function automatic msg_item_t make_item(input logic [7:0] b, input bit v, input bit e);
        msg_item_t it;
        it.data_byte      = b;
        it.byte_valid     = v;
        it.end_of_message = e;
        return it;
    endfunction

    // Queue a message of n random bytes; the end flag rides on the last byte
    // or, at random, on a separate item with no byte.
    task automatic queue_message(input int n);
        bit separate_end;
        separate_end = (n == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
            pending_items.push_back(make_item(8'($urandom_range(0, 255)), 1'b1,
                                              !separate_end && (i == n - 1)));
        if (separate_end)
            pending_items.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Driver: bursts of offered items separated by random gaps. Valid is only
    // lowered once the current item has been taken.
    int burst_left = 0;
    int gap_left   = 0;
    bit pause_for_drain = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            msg       <= '0;
        end
        else if (!msg_valid || msg_taken)
        begin
            if (msg_valid)
            begin
                absorb_item(pending_items.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left--;
                msg_valid <= 1'b0;
            end
            else if (pause_for_drain && expected_words.size() != 0)
                msg_valid <= 1'b0;
            else if (pending_items.size() != 0)
            begin
                msg       <= pending_items[0];
                msg_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                msg_valid <= 1'b0;
        end
    end

    // Note: acceptance is recorded by the monitor at the rising edge, since
    // ready may already have changed by the following falling edge.

    // Receiver stall pattern: stretches of always-ready and stretches of
    // random stalls, plus one long hold started at the first digest item.
    int stall_phase = 0;
    int hold_left   = 0;
    bit hold_done   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            digest_ready <= 1'b0;
        else
        begin
            if (!hold_done && digest_valid)
            begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            hold_receiver = (hold_left > 0);
            if (hold_left > 0)
            begin
                hold_left--;
                digest_ready <= 1'b0;
            end
            else
            begin
                stall_phase = (stall_phase + 1) % 300;
                if (stall_phase < 100)
                    digest_ready <= 1'b1;
                else if (stall_phase < 200)
                    digest_ready <= ($urandom_range(0, 3) != 0);
                else
                    digest_ready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (!rst_n)
            msg_taken = 1'b0;
        else
        begin
            msg_taken = msg_valid && msg_ready;
            if (digest_valid && digest_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("digest item with no expected word: %h", digest.digest_word);
                    error_count++;
                end
                else
                begin
                    digest_item_t e;
                    e = expected_words.pop_front();
                    if (digest.digest_word !== e.digest_word)
                    begin
                        $error("digest_word expected %h got %h", e.digest_word,
                               digest.digest_word);
                        error_count++;
                    end
                    if (digest.word_index !== e.word_index)
                    begin
                        $error("word_index expected %0d got %0d", e.word_index,
                               digest.word_index);
                        error_count++;
                    end
                    if (digest.last_word !== e.last_word)
                    begin
                        $error("last_word expected %0d got %0d", e.last_word,
                               digest.last_word);
                        error_count++;
                    end
                end
            end
            if ((msg_valid && msg_ready) || (digest_valid && digest_ready))
                idle_cycles = 0;
            else if (hold_receiver || (!msg_valid && expected_words.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("FAIL salted_sha256_variant_hash");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int n;
        hash_restart();
        for (int i = 0; i < 64; i++)
            block_bytes[i] = 8'h00;
        @(posedge rst_n);

        // Directed: empty message, byte and end together, extreme bytes,
        // pad boundaries at 55 and 56 bytes, and an exactly full block.
        queue_message(0);
        pending_items.push_back(make_item(8'h00, 1'b1, 1'b1));
        pending_items.push_back(make_item(8'hFF, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h00, 1'b0, 1'b0));
        pending_items.push_back(make_item(8'hA5, 1'b1, 1'b1));
        queue_message(55);
        queue_message(56);
        queue_message(64);

        // Random messages, mostly short, a few spanning several blocks.
        // Idle items without a byte or end are mixed in as noise.
        while (pending_items.size() < 430)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 20);
            if ($urandom_range(0, 5) == 0)
                pending_items.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            queue_message(n);
        end

        // Later, pause the sender until every expected word has arrived.
        wait (pending_items.size() < 300);
        pause_for_drain = 1'b1;
        wait (expected_words.size() == 0);
        @(posedge clk);
        pause_for_drain = 1'b0;

        wait (pending_items.size() == 0 && !msg_valid);
        wait (expected_words.size() == 0);
        repeat (400) @(posedge clk);

        if (error_count == 0 && expected_words.size() == 0)
            $display("PASS salted_sha256_variant_hash");
        else
            $display("FAIL salted_sha256_variant_hash");
        $finish;
    end

endmodule
